// ----- design/kart_pkg.sv -----
// Shared constants, record types and register codes of the key auto-repeat table.
package kart_pkg;

  localparam int KEYS      = 256;
  localparam int TIME_BITS = 48;

  localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int FDUR_W  = 20;
  localparam int FRM_W   = 8;
  localparam int DLY_W   = FDUR_W + FRM_W;
  localparam int SUM_W   = ((TIME_BITS > DLY_W) ? TIME_BITS : DLY_W) + 1;
  localparam int COUNT_W = 16;
  localparam int FRAME_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [FDUR_W-1:0] FDUR_RESET = FDUR_W'(16667);
  localparam logic [FRM_W-1:0]  IDLY_RESET = FRM_W'(15);
  localparam logic [FRM_W-1:0]  RINT_RESET = FRM_W'(4);

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_DUR = 2'd0;
  localparam logic [1:0] REG_INIT_DLY  = 2'd1;
  localparam logic [1:0] REG_RPT_INT   = 2'd2;

  // One key's repeat record as kept in the table memory.
  typedef struct packed {
    logic                 hold_active;
    logic [COUNT_W-1:0]   count;
    logic                 start_valid;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] last_repeat_time;
    logic [FRAME_W-1:0]   last_frame;
    logic                 last_fired;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Query fields held while the record is read.
  typedef struct packed {
    logic                 pressed;
    logic                 just_pressed;
    logic                 press_time_known;
    logic [TIME_BITS-1:0] press_time;
    logic [TIME_BITS-1:0] now_time;
    logic [FRAME_W-1:0]   frame_number;
  } qry_t;

  // Status from the update logic back to the control.
  typedef struct packed {
    logic               write_en;
    logic               fired;
    logic [COUNT_W-1:0] count;
  } upd_t;

endpackage

// ----- design/kart_if.sv -----
// Valid/ready channel interfaces for query items and result items.
interface kart_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  key_index;
  logic        pressed;
  logic        just_pressed;
  logic        press_time_known;
  logic [47:0] press_time;
  logic [47:0] now_time;
  logic [31:0] frame_number;

  modport source (output valid, key_index, pressed, just_pressed, press_time_known,
                  press_time, now_time, frame_number, input ready);
  modport sink   (input valid, key_index, pressed, just_pressed, press_time_known,
                  press_time, now_time, frame_number, output ready);
endinterface

interface kart_out_if;
  logic        valid;
  logic        ready;
  logic        repeat_fired;
  logic [15:0] repeat_count;

  modport source (output valid, repeat_fired, repeat_count, input ready);
  modport sink   (input valid, repeat_fired, repeat_count, output ready);
endinterface

// ----- design/kart_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/kart_update.sv -----
// Next-record and result logic for one key query.
module kart_update (
  input  kart_pkg::qry_t              qry,
  input  logic                        rec_ok,
  input  kart_pkg::rec_t              rec_raw,
  input  logic [kart_pkg::DLY_W-1:0]  delay_us,
  input  logic [kart_pkg::DLY_W-1:0]  interval_us,
  output kart_pkg::rec_t              rec_new,
  output kart_pkg::upd_t              upd
);
  import kart_pkg::*;

  rec_t                 rec;
  logic [TIME_BITS-1:0] start;
  logic [SUM_W-1:0]     due;
  logic                 cached;
  logic                 fired;

  always_comb begin
    // A key that was never written reads as an all-zero record.
    rec    = rec_ok ? rec_raw : '0;
    start  = qry.press_time_known ? qry.press_time : qry.now_time;
    cached = rec_ok && (rec.last_frame == qry.frame_number);
    fired  = 1'b0;
    due    = '0;
    rec_new = rec;

    if (qry.just_pressed) begin
      rec_new.hold_active      = 1'b1;
      rec_new.count            = '0;
      rec_new.start_valid      = 1'b1;
      rec_new.start_time       = start;
      rec_new.last_repeat_time = start;
    end else if (!qry.pressed) begin
      rec_new.hold_active      = 1'b0;
      rec_new.count            = '0;
      rec_new.start_valid      = 1'b0;
      rec_new.start_time       = '0;
      rec_new.last_repeat_time = '0;
    end else begin
      if (!rec_new.hold_active) begin
        rec_new.hold_active      = 1'b1;
        rec_new.count            = '0;
        rec_new.start_valid      = 1'b1;
        rec_new.start_time       = start;
        rec_new.last_repeat_time = start;
      end
      if (!rec_new.start_valid) begin
        rec_new.start_valid = 1'b1;
        rec_new.start_time  = start;
      end
      // The first repeat counts from the press, later ones from the last deadline.
      if (rec_new.count == '0) begin
        due = SUM_W'(rec_new.start_time) + SUM_W'(delay_us);
      end else begin
        due = SUM_W'(rec_new.last_repeat_time) + SUM_W'(interval_us);
      end
      if (SUM_W'(qry.now_time) >= due) begin
        if (rec_new.count != COUNT_MAX) begin
          rec_new.count = rec_new.count + COUNT_W'(1);
        end
        rec_new.last_repeat_time = due[TIME_BITS-1:0];
        fired = 1'b1;
      end
    end
    rec_new.last_frame = qry.frame_number;
    rec_new.last_fired = fired;

    if (cached) begin
      upd.write_en = 1'b0;
      upd.fired    = rec.last_fired;
      upd.count    = rec.count;
    end else begin
      upd.write_en = 1'b1;
      upd.fired    = fired;
      upd.count    = rec_new.count;
    end
  end

endmodule

// ----- design/key_auto_repeat_table.sv -----
// Top level of the per-key auto-repeat table: control, configuration and record memory.
// The record memory is read at the edge that accepts a query item. Once the result
// register is free or being emptied, the updated record is written back and the result
// register is loaded. No new item is taken until then; a stalled result holds it off.
// Reset (synchronous, active low) restores the register defaults and clears one valid
// flip-flop per key at once, so there is no clearing pass over the memory.
module key_auto_repeat_table (
  input  logic                          clk,
  input  logic                          rst_n,
  kart_in_if.sink                       in_ch,
  kart_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [kart_pkg::FDUR_W-1:0]   cfg_data
);
  import kart_pkg::*;

  // The control walks between taking an item and updating its record.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers and the derived delay and interval in microseconds.
  logic [FDUR_W-1:0] frame_dur_r;
  logic [FRM_W-1:0]  init_dly_r;
  logic [FRM_W-1:0]  rpt_int_r;
  logic [DLY_W-1:0]  delay_us_r;
  logic [DLY_W-1:0]  interval_us_r;

  // The query item held while its record is read and updated.
  qry_t              qry_r;
  logic [KEY_W-1:0]  key_r;
  logic              key_oor_r;

  // One valid bit per key; a key without it reads as the all-zero record.
  logic [KEYS-1:0]   entry_valid_r;

  logic              out_valid_r;
  logic              out_fired_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [31:0]       key_wide;
  logic              in_accept;
  logic              go;
  logic [KEY_W-1:0]  rd_addr;
  logic [REC_W-1:0]  rd_data;
  rec_t              rec_new;
  upd_t              upd;
  logic              mem_we;

  assign key_wide  = 32'(in_ch.key_index);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept = in_ch.valid && in_ch.ready;

  // The update may finish once the output register is free or being emptied.
  assign go     = (state_r == S_CALC) && (!out_valid_r || out_ch.ready);
  assign mem_we = go && upd.write_en && !key_oor_r;

  // The read address holds on the current key while the update waits, so the
  // registered read data stays put.
  assign rd_addr = (state_r == S_IDLE) ? key_wide[KEY_W-1:0] : key_r;

  kart_ram #(
    .WIDTH (REC_W),
    .DEPTH (KEYS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (key_r),
    .wdata (rec_new),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kart_update u_update (
    .qry         (qry_r),
    .rec_ok      (entry_valid_r[key_r]),
    .rec_raw     (rec_t'(rd_data)),
    .delay_us    (delay_us_r),
    .interval_us (interval_us_r),
    .rec_new     (rec_new),
    .upd         (upd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
      frame_dur_r   <= FDUR_RESET;
      init_dly_r    <= IDLY_RESET;
      rpt_int_r     <= RINT_RESET;
      delay_us_r    <= DLY_W'(IDLY_RESET) * DLY_W'(FDUR_RESET);
      interval_us_r <= DLY_W'(RINT_RESET) * DLY_W'(FDUR_RESET);
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_DUR: frame_dur_r <= cfg_data;
          REG_INIT_DLY:  init_dly_r  <= cfg_data[FRM_W-1:0];
          REG_RPT_INT:   rpt_int_r   <= cfg_data[FRM_W-1:0];
          default: begin
          end
        endcase
      end
      // The products are registered, so they follow a register change in the cycle after it.
      delay_us_r    <= DLY_W'(init_dly_r) * DLY_W'(frame_dur_r);
      interval_us_r <= DLY_W'(rpt_int_r) * DLY_W'(frame_dur_r);

      if (mem_we) begin
        entry_valid_r[key_r] <= 1'b1;
      end

      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_r                  <= key_wide[KEY_W-1:0];
      key_oor_r              <= (key_wide >= 32'(KEYS));
      qry_r.pressed          <= in_ch.pressed;
      qry_r.just_pressed     <= in_ch.just_pressed;
      qry_r.press_time_known <= in_ch.press_time_known;
      qry_r.press_time       <= in_ch.press_time[TIME_BITS-1:0];
      qry_r.now_time         <= in_ch.now_time[TIME_BITS-1:0];
      qry_r.frame_number     <= in_ch.frame_number;
    end
    if (go) begin
      // A key beyond the table answers with no repeat and a zero count.
      out_fired_r <= key_oor_r ? 1'b0 : upd.fired;
      out_count_r <= key_oor_r ? '0 : upd.count;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.repeat_fired = out_fired_r;
  assign out_ch.repeat_count = out_count_r;

endmodule

// ----- tb/sv/auto_repeat_checker.sv -----
// Checker that predicts each key query's repeat answer and compares it with the table output.
`timescale 1ns / 1ps
module auto_repeat_checker
  import kart_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  kart_in_if                in_mon,
  kart_out_if               out_mon,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [FDUR_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending,
  output int                answers_checked,
  output int                repeats_fired,
  output int                same_frame_answers
);

  typedef struct packed {
    logic               fired;
    logic [COUNT_W-1:0] count;
  } repeat_answer_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key_idx;
    logic                 pressed;
    logic                 just_pressed;
    logic                 time_known;
    logic [TIME_BITS-1:0] press_time;
    logic [TIME_BITS-1:0] now_time;
    logic [FRAME_W-1:0]   frame;
  } key_query_t;

  typedef struct packed {
    logic                 seen;
    logic                 holding;
    logic                 started;
    logic [COUNT_W-1:0]   count;
    logic [TIME_BITS-1:0] t_start;
    logic [TIME_BITS-1:0] t_last;
    logic [FRAME_W-1:0]   frame;
    logic                 fired;
  } key_state_t;

  key_state_t        key_tab [KEYS];
  logic [FDUR_W-1:0] frame_us;
  logic [FRM_W-1:0]  delay_frames;
  logic [FRM_W-1:0]  interval_frames;
  repeat_answer_t    awaited [$];

  function automatic key_state_t fresh_run(input key_state_t s, input logic [TIME_BITS-1:0] t);
    s.holding = 1'b1;
    s.count   = '0;
    s.started = 1'b1;
    s.t_start = t;
    s.t_last  = t;
    return s;
  endfunction

  // Works out the answer to one query and updates that key's record.
  function automatic repeat_answer_t predict_repeat(input key_query_t q);
    key_state_t           s;
    logic [SUM_W-1:0]     due;
    logic [TIME_BITS-1:0] t0;
    repeat_answer_t       ans;
    s  = key_tab[q.key_idx];
    t0 = q.time_known ? q.press_time : q.now_time;
    ans.fired = 1'b0;
    // A key already evaluated in this frame repeats its earlier answer.
    if (s.seen && s.frame == q.frame) begin
      same_frame_answers++;
      ans.fired = s.fired;
      ans.count = s.count;
      return ans;
    end
    s.seen = 1'b1;
    if (q.just_pressed) begin
      s = fresh_run(s, t0);
    end else if (!q.pressed) begin
      s.holding = 1'b0;
      s.count   = '0;
      s.started = 1'b0;
      s.t_start = '0;
      s.t_last  = '0;
    end else begin
      if (!s.holding) s = fresh_run(s, t0);
      if (!s.started) begin
        s.started = 1'b1;
        s.t_start = t0;
      end
      // Deadlines are one bit wider than a time, so a late one is simply never met.
      if (s.count == '0)
        due = SUM_W'(s.t_start) + SUM_W'(delay_frames) * SUM_W'(frame_us);
      else
        due = SUM_W'(s.t_last) + SUM_W'(interval_frames) * SUM_W'(frame_us);
      if (SUM_W'(q.now_time) >= due) begin
        if (s.count != COUNT_MAX) s.count++;
        s.t_last  = due[TIME_BITS-1:0];
        ans.fired = 1'b1;
      end
    end
    s.frame = q.frame;
    s.fired = ans.fired;
    key_tab[q.key_idx] = s;
    ans.count = s.count;
    return ans;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    repeat_answer_t want;
    key_query_t     q;
    if (!rst_n) begin
      foreach (key_tab[k]) key_tab[k] = '0;
      frame_us           = FDUR_RESET;
      delay_frames       = IDLY_RESET;
      interval_frames    = RINT_RESET;
      awaited.delete();
      fail_count         = 0;
      answers_checked    = 0;
      repeats_fired      = 0;
      same_frame_answers = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_DUR: frame_us        = cfg_data;
          REG_INIT_DLY:  delay_frames    = cfg_data[FRM_W-1:0];
          REG_RPT_INT:   interval_frames = cfg_data[FRM_W-1:0];
          default: ;
        endcase
      end
      // Results leave before the query of the same edge is predicted.
      if (out_mon.valid && out_mon.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("result fired=%0b count=%0d with no query waiting",
                                    out_mon.repeat_fired, out_mon.repeat_count));
        end else begin
          want = awaited.pop_front();
          answers_checked++;
          if (want.fired) repeats_fired++;
          if (out_mon.repeat_fired !== want.fired)
            report_mismatch($sformatf("repeat_fired %b, predicted %b",
                                      out_mon.repeat_fired, want.fired));
          if (out_mon.repeat_count !== want.count)
            report_mismatch($sformatf("repeat_count %0d, predicted %0d",
                                      out_mon.repeat_count, want.count));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        q.key_idx      = in_mon.key_index;
        q.pressed      = in_mon.pressed;
        q.just_pressed = in_mon.just_pressed;
        q.time_known   = in_mon.press_time_known;
        q.press_time   = in_mon.press_time;
        q.now_time     = in_mon.now_time;
        q.frame        = in_mon.frame_number;
        awaited.push_back(predict_repeat(q));
      end
    end
    pending = awaited.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the key auto-repeat table testbench: clock, reset, query stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import kart_pkg::*;

  // Index that has no register behind it; a write there must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Default timing in microseconds: 15 frames of delay, 4 frames of interval.
  localparam logic [TIME_BITS-1:0] DEF_DELAY = TIME_BITS'(15 * 16667);
  localparam logic [TIME_BITS-1:0] DEF_STEP  = TIME_BITS'(4 * 16667);

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [FDUR_W-1:0] cfg_data;

  kart_in_if  in_ch ();
  kart_out_if out_ch ();

  int fail_count;
  int pending;
  int answers_checked;
  int repeats_fired;
  int same_frame_answers;

  key_auto_repeat_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  auto_repeat_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .answers_checked    (answers_checked),
    .repeats_fired      (repeats_fired),
    .same_frame_answers (same_frame_answers)
  );

  // Stimulus state. The testbench keeps its own notion of the frame counter,
  // the poll time and which pool keys it believes are held, so that most
  // queries form realistic hold sequences long enough to reach repeats.
  bit                   idle_on;
  logic [FRAME_W-1:0]   frame_ctr;
  logic [TIME_BITS-1:0] now_us;
  logic [FDUR_W-1:0]    frame_us;
  int                   stride;
  bit                   key_down [KEYS];
  logic [KEY_W-1:0]     key_pool [8];
  logic [KEY_W-1:0]     last_key;
  int                   settings_used;
  int                   queries_sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is bounded no matter what the block does.
  initial begin
    #300_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: ready drops in random bursts while idling is on, and
  // stays high otherwise. It changes only on falling edges.
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  // Presents one query item and returns at the edge where it is taken.
  // A random gap may come first; valid is held high across back-to-back items.
  task automatic send_query(input logic [KEY_W-1:0] k, input logic pr, input logic js,
                            input logic kn, input logic [TIME_BITS-1:0] pt,
                            input logic [TIME_BITS-1:0] nt, input logic [FRAME_W-1:0] fr);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.key_index        <= k;
    in_ch.pressed          <= pr;
    in_ch.just_pressed     <= js;
    in_ch.press_time_known <= kn;
    in_ch.press_time       <= pt;
    in_ch.now_time         <= nt;
    in_ch.frame_number     <= fr;
    do @(posedge clk); while (!in_ch.ready);
    queries_sent++;
  endtask

  // Stops sending and waits until every predicted answer has come back,
  // then lets the block settle.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [FDUR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_timing(input logic [FDUR_W-1:0] fdur, input logic [FRM_W-1:0] idly,
                            input logic [FRM_W-1:0] rint);
    write_reg(REG_FRAME_DUR, fdur);
    write_reg(REG_INIT_DLY, FDUR_W'(idly));
    write_reg(REG_RPT_INT, FDUR_W'(rint));
    frame_us = fdur;
    settings_used++;
  endtask

  // The extreme keys always sit in the pool; the rest change per phase.
  task automatic refresh_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = KEY_W'($urandom_range(1, 254));
  endtask

  // Mostly well-formed press/hold/release sequences on the pool keys with
  // frames and time moving forward, plus same-frame re-queries and a share
  // of fully random noise items.
  task automatic random_queries(input int n);
    logic [KEY_W-1:0]     k;
    logic                 pr;
    logic                 js;
    logic                 kn;
    logic [TIME_BITS-1:0] pt;
    int                   pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_query(KEY_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), rand_time(),
                   ($urandom_range(0, 1) == 1) ? now_us : rand_time(),
                   ($urandom_range(0, 1) == 1) ? frame_ctr : FRAME_W'($urandom));
      end else if (pick < 16) begin
        // Same key, same frame: the table must answer from its record.
        send_query(last_key, 1'($urandom), 1'($urandom), 1'($urandom), rand_time(),
                   now_us, frame_ctr);
      end else begin
        k = key_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 1) == 1) begin
          frame_ctr++;
          now_us += TIME_BITS'(frame_us) * TIME_BITS'($urandom_range(1, stride))
                    + TIME_BITS'($urandom_range(0, 40));
        end
        if (!key_down[k]) begin
          if ($urandom_range(0, 3) == 0) begin
            pr = 1'b0;
            js = 1'b0;
          end else begin
            // Usually a proper press; sometimes a hold seen without its press edge,
            // or a press edge reported without the held flag.
            js = ($urandom_range(0, 4) != 0);
            pr = js ? ($urandom_range(0, 5) != 0) : 1'b1;
            key_down[k] = 1'b1;
          end
        end else if ($urandom_range(0, 39) == 0) begin
          pr = 1'b0;
          js = 1'b0;
          key_down[k] = 1'b0;
        end else begin
          pr = 1'b1;
          js = ($urandom_range(0, 29) == 0);
        end
        kn = 1'($urandom_range(0, 1));
        pt = now_us - TIME_BITS'($urandom_range(0, 3000));
        last_key = k;
        send_query(k, pr, js, kn, pt, now_us, frame_ctr);
      end
      // Now and then the sender holds off until the table has caught up.
      if ($urandom_range(0, 299) == 0) wait_for_results();
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = REG_FRAME_DUR;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.key_index        = '0;
    in_ch.pressed          = 1'b0;
    in_ch.just_pressed     = 1'b0;
    in_ch.press_time_known = 1'b0;
    in_ch.press_time       = '0;
    in_ch.now_time         = '0;
    in_ch.frame_number     = '0;
    idle_on                = 1'b1;
    frame_ctr              = '0;
    now_us                 = '0;
    frame_us               = FDUR_RESET;
    stride                 = 1;
    last_key               = '0;
    settings_used          = 1;
    queries_sent           = 0;
    refresh_pool();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset timing. The very first query of a key
    // must not be taken as a same-frame answer even though its frame is 0.
    send_query(8'h00, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0);
    send_query(8'h00, 1'b1, 1'b1, 1'b1, '1, '0, 32'd0);
    // Both flags set start a fresh run; then the first repeat lands exactly
    // on the delay, the second on the interval, and a late poll catches up
    // by one interval only.
    send_query(8'hFF, 1'b1, 1'b1, 1'b1, 48'd1000, 48'd1200, 32'd1);
    send_query(8'hFF, 1'b1, 1'b0, 1'b0, '1, 48'd1000 + DEF_DELAY - 1, 32'd2);
    send_query(8'hFF, 1'b1, 1'b0, 1'b0, '0, 48'd1000 + DEF_DELAY, 32'd3);
    send_query(8'hFF, 1'b1, 1'b0, 1'b1, '0, 48'd1000 + DEF_DELAY + DEF_STEP, 32'd4);
    send_query(8'hFF, 1'b0, 1'b0, 1'b0, '0, 48'd9, 32'd4);
    send_query(8'hFF, 1'b1, 1'b0, 1'b0, '0, 48'd1000 + DEF_DELAY + 11 * DEF_STEP, 32'd5);
    send_query(8'hFF, 1'b0, 1'b0, 1'b1, 48'd77, 48'd1_900_000, 32'd6);
    // A hold seen without a press starts its run from the given press time.
    send_query(8'hFF, 1'b1, 1'b0, 1'b1, 48'd1_700_000, 48'd2_000_000, 32'd7);
    // Near the top of the time range the deadline goes past the last
    // representable time and is never reached; the frame counter wraps too.
    send_query(8'h5A, 1'b1, 1'b1, 1'b0, '0, 48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF);
    send_query(8'h5A, 1'b1, 1'b0, 1'b0, '0, 48'hFFFF_FFFF_FFFF, 32'd0);
    send_query(8'hA5, 1'b1, 1'b0, 1'b0, '0, 48'd5, 32'd0);
    send_query(8'hA5, 1'b0, 1'b1, 1'b1, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 32'd1);
    send_query(8'hA5, 1'b1, 1'b0, 1'b0, '0, 48'h8000_0000_0000 + DEF_DELAY, 32'd2);
    send_query(8'h00, 1'b0, 1'b0, 1'b1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
               32'h5555_AAAA);

    // Random part at the reset timing.
    now_us    = 48'd3_000_000;
    frame_ctr = 32'd8;
    random_queries(400);

    // Shortest frame, no delay, one-frame interval; the frame counter starts close to wrapping.
    wait_for_results();
    set_timing(FDUR_W'(1), 8'd0, 8'd1);
    stride    = 1;
    frame_ctr = 32'hFFFF_FF80;
    refresh_pool();
    random_queries(250);

    // Long frame with the longest delay and interval; frames jump far.
    wait_for_results();
    set_timing(FDUR_W'(1_000_000), 8'd255, 8'd255);
    stride = 64;
    now_us = rand_time() >> 2;
    refresh_pool();
    random_queries(250);

    // Zero frame length and zero interval: every new frame repeats. The
    // delay is written with junk above its eight bits, and the unused index
    // is written as well.
    wait_for_results();
    write_reg(REG_FRAME_DUR, '0);
    write_reg(REG_RPT_INT, '0);
    write_reg(REG_INIT_DLY, 20'hABC07);
    write_reg(REG_UNUSED, '1);
    frame_us = '0;
    settings_used++;
    stride = 4;
    refresh_pool();
    random_queries(200);

    // From here on neither side idles. One key is held across a run of new
    // frames with zero timing, so it repeats on every one of them.
    wait_for_results();
    idle_on = 1'b0;
    set_timing('0, 8'd0, 8'd0);
    frame_ctr++;
    send_query(8'hC3, 1'b1, 1'b1, 1'b0, '0, now_us, frame_ctr);
    for (int i = 0; i < 30; i++) begin
      frame_ctr++;
      send_query(8'hC3, 1'b1, 1'b0, 1'b0, '0, now_us, frame_ctr);
    end

    // Last stretch: an ordinary timing with times high in the range.
    wait_for_results();
    set_timing(FDUR_W'(523), 8'd3, 8'd2);
    stride = 2;
    now_us = 48'hFFFF_F000_0000 | TIME_BITS'($urandom_range(0, 65535));
    refresh_pool();
    random_queries(400);

    wait_for_results();
    repeat (4) @(negedge clk);

    $display("Covered %0d query items over %0d register settings; %0d results checked.",
             queries_sent, settings_used, answers_checked);
    $display("%0d repeats fired, %0d same-frame answers, one key repeating every frame.",
             repeats_fired, same_frame_answers);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/kart_pkg.sv
design/kart_if.sv
design/kart_ram.sv
design/kart_update.sv
design/key_auto_repeat_table.sv
tb/sv/auto_repeat_checker.sv
tb/sv/tb_top.sv
